>>> sv/scds_pkg.sv
// ----------------------------------------------------------------------------
// scds_pkg
// Shared constants and types for the sorted chord dictionary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package scds_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int STROKE_SLOTS = 16;

    localparam int ENTRY_W  = $clog2(MAX_ENTRIES);
    localparam int SLOT_W   = 5;
    localparam int ADDR_W   = ENTRY_W + SLOT_W;
    localparam int WORD_W   = 32;
    localparam int KIDX_W   = $clog2(STROKE_SLOTS);
    localparam int LEN_W    = 5;
    localparam int TOTAL_W  = 11;
    localparam int SPE_W    = 5;

    localparam logic [SLOT_W-1:0] OFFSET_SLOT = SLOT_W'(STROKE_SLOTS);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_STROKE = 1'b1;

    localparam logic CFG_STROKES = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;

    typedef struct packed {
        logic              clear;
        logic              valid;
        logic [KIDX_W-1:0] idx;
    } cmp_ctrl_t;

    typedef struct packed {
        logic full_lt;
        logic full_gt;
        logic pre_ge;
        logic pre_eq;
        logic ext_nz;
    } cmp_res_t;

endpackage

`default_nettype wire

>>> sv/scds_table_ram.sv
// ----------------------------------------------------------------------------
// scds_table_ram
// Table word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_table_ram
(
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [scds_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [scds_pkg::WORD_W-1:0]  wdata,
    input  wire logic                         re,
    input  wire logic [scds_pkg::ADDR_W-1:0]  raddr,
    output logic      [scds_pkg::WORD_W-1:0]  rdata
);
    import scds_pkg::*;

    logic [WORD_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/scds_cmp.sv
// ----------------------------------------------------------------------------
// scds_cmp
// Shared stroke compare unit: takes one entry word a cycle and builds the
// full-key and prefix orderings of the entry under probe.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_cmp
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire scds_pkg::cmp_ctrl_t          ctrl,
    input  wire logic [scds_pkg::WORD_W-1:0]  word,
    input  wire logic [scds_pkg::WORD_W-1:0]  key_word,
    input  wire logic [scds_pkg::LEN_W-1:0]   count,
    output scds_pkg::cmp_res_t                res
);
    import scds_pkg::*;

    logic              diff_reg, diff_next;
    logic              key_lt_reg, key_lt_next;
    logic [LEN_W-1:0]  diff_idx_reg, diff_idx_next;
    logic [LEN_W-1:0]  elen_reg, elen_next;
    logic              ext_nz_reg, ext_nz_next;
    logic [LEN_W-1:0]  idx_ext;
    logic [LEN_W-1:0]  n_cmp;
    logic              diff_in;

    assign idx_ext = LEN_W'(ctrl.idx);

    always_comb
    begin
        diff_next     = diff_reg;
        key_lt_next   = key_lt_reg;
        diff_idx_next = diff_idx_reg;
        elen_next     = elen_reg;
        ext_nz_next   = ext_nz_reg;
        if (ctrl.clear)
        begin
            diff_next   = 1'b0;
            key_lt_next = 1'b0;
            diff_idx_next = '0;
            elen_next   = '0;
            ext_nz_next = 1'b0;
        end
        else if (ctrl.valid)
        begin
            // record only the first differing stroke within the key
            if (!diff_reg && idx_ext < count && word != key_word)
            begin
                diff_next     = 1'b1;
                key_lt_next   = key_word < word;
                diff_idx_next = idx_ext;
            end
            if (word != '0)
            begin
                elen_next = idx_ext + LEN_W'(1);
            end
            if (idx_ext == count && word != '0)
            begin
                ext_nz_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg     <= 1'b0;
            key_lt_reg   <= 1'b0;
            diff_idx_reg <= '0;
            elen_reg     <= '0;
            ext_nz_reg   <= 1'b0;
        end
        else
        begin
            diff_reg     <= diff_next;
            key_lt_reg   <= key_lt_next;
            diff_idx_reg <= diff_idx_next;
            elen_reg     <= elen_next;
            ext_nz_reg   <= ext_nz_next;
        end
    end

    assign n_cmp   = (count < elen_reg) ? count : elen_reg;
    assign diff_in = diff_reg && (diff_idx_reg < n_cmp);

    always_comb
    begin
        res.full_lt = diff_in ? key_lt_reg  : (count < elen_reg);
        res.full_gt = diff_in ? !key_lt_reg : (count > elen_reg);
        res.pre_ge  = !(diff_reg && !key_lt_reg);
        res.pre_eq  = !diff_reg;
        res.ext_nz  = ext_nz_reg;
    end

endmodule

`default_nettype wire

>>> sv/sorted_chord_dictionary_search.sv
// ----------------------------------------------------------------------------
// sorted_chord_dictionary_search
// Sorted stroke table with exact-match and longer-entry binary searches.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes requests. tuser = 0 writes one table word
// (no result; a word_slot past 16 is dropped); tuser = 1 appends one key
// stroke, and tlast on a stroke starts the search, which yields one result
// on the m_ channel. After a table write or a non-final stroke the block
// stays ready for the next request. A search runs a binary search over
// entries_in_use entries for the exact key, each probe reading
// strokes_per_entry words through the single table read port, one more
// read for the offset on a hit, then a second binary search reading
// key-length words per probe and a forward scan reading key-length plus
// one words per entry. s_tready is low while a search runs. The result
// sits in an output register; a finished search holds in its last state
// with s_tready low until that register is free. Reset clears the key,
// the registers (16 slots, 0 entries) and the output; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_chord_dictionary_search
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_addr,
    input  wire logic [scds_pkg::TOTAL_W-1:0]   cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index[9:0], word_slot[14:10], word_value[46:15], key_stroke[78:47]
    input  wire logic [scds_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // found[0], string_offset[32:1], has_longer[33], key_too_long[34]
    output logic      [scds_pkg::M_DATA_W-1:0]  m_tdata
);
    import scds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_F_CHECK, ST_P_INIT, ST_P_CHECK, ST_S_CHECK,
        ST_READ, ST_DRAIN, ST_EVAL, ST_OFS_READ, ST_OFS_WAIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_FULL, MODE_PREFIX, MODE_SCAN
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [SPE_W-1:0]   spe_reg;
    logic [TOTAL_W-1:0] eiu_reg;
    logic [WORD_W-1:0]  key_reg [STROKE_SLOTS];
    logic [LEN_W-1:0]   key_len_reg;
    logic               key_ovf_reg;
    logic [TOTAL_W-1:0] lo_reg, lo_next;
    logic [TOTAL_W-1:0] hi_reg, hi_next;
    logic [TOTAL_W-1:0] first_reg, first_next;
    logic [TOTAL_W-1:0] probe_reg, probe_next;
    logic [LEN_W-1:0]   rd_len_reg, rd_len_next;
    logic [LEN_W-1:0]   rd_i_reg, rd_i_next;
    logic               dv_reg;
    logic [KIDX_W-1:0]  di_reg;
    logic               found_reg, found_next;
    logic [WORD_W-1:0]  offset_reg, offset_next;
    logic               longer_reg, longer_next;
    logic               ovf_res_reg, ovf_res_next;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [LEN_W-1:0]   slots;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] mid;
    logic               s_fire;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic               out_free;
    logic               load_out;
    logic               key_clear;
    cmp_ctrl_t          cmp_ctrl;
    cmp_res_t           cmp_res;

    logic [ENTRY_W-1:0] in_entry;
    logic [SLOT_W-1:0]  in_slot;
    logic [WORD_W-1:0]  in_value;
    logic [WORD_W-1:0]  in_stroke;

    assign in_entry  = s_tdata[ENTRY_W-1:0];
    assign in_slot   = s_tdata[ENTRY_W+SLOT_W-1:ENTRY_W];
    assign in_value  = s_tdata[ENTRY_W+SLOT_W+WORD_W-1:ENTRY_W+SLOT_W];
    assign in_stroke = s_tdata[ENTRY_W+SLOT_W+2*WORD_W-1:ENTRY_W+SLOT_W+WORD_W];

    assign slots = (spe_reg > SPE_W'(STROKE_SLOTS)) ? LEN_W'(STROKE_SLOTS) : spe_reg;
    assign total = (eiu_reg > TOTAL_W'(MAX_ENTRIES)) ? TOTAL_W'(MAX_ENTRIES) : eiu_reg;
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign ram_we   = s_fire && (s_tuser == ACT_WRITE) && (in_slot <= OFFSET_SLOT);
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign key_clear = load_out;

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = {probe_reg[ENTRY_W-1:0], rd_i_reg};
        if (state_reg == ST_READ)
        begin
            ram_re = 1'b1;
        end
        else if (state_reg == ST_OFS_READ)
        begin
            ram_re    = 1'b1;
            ram_raddr = {probe_reg[ENTRY_W-1:0], OFFSET_SLOT};
        end
    end

    scds_table_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_entry, in_slot}),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cmp_ctrl.clear = (state_reg == ST_F_CHECK) || (state_reg == ST_P_CHECK)
                         || (state_reg == ST_S_CHECK);
        cmp_ctrl.valid = dv_reg;
        cmp_ctrl.idx   = di_reg;
    end

    scds_cmp u_cmp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cmp_ctrl),
        .word     (ram_rdata),
        .key_word (key_reg[di_reg]),
        .count    (key_len_reg),
        .res      (cmp_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        first_next   = first_reg;
        probe_next   = probe_reg;
        rd_len_next  = rd_len_reg;
        rd_i_next    = rd_i_reg;
        found_next   = found_reg;
        offset_next  = offset_reg;
        longer_next  = longer_reg;
        ovf_res_next = ovf_res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && s_tuser == ACT_STROKE && s_tlast)
                begin
                    found_next  = 1'b0;
                    offset_next = '0;
                    longer_next = 1'b0;
                    if (key_ovf_reg || key_len_reg == LEN_W'(STROKE_SLOTS))
                    begin
                        ovf_res_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        ovf_res_next = 1'b0;
                        state_next   = ST_START;
                    end
                end
            end
            ST_START:
            begin
                lo_next = '0;
                hi_next = total;
                if (key_len_reg != '0 && key_len_reg <= slots)
                begin
                    state_next = ST_F_CHECK;
                end
                else
                begin
                    state_next = ST_P_INIT;
                end
            end
            ST_F_CHECK:
            begin
                if (lo_reg < hi_reg)
                begin
                    probe_next  = mid;
                    rd_len_next = slots;
                    rd_i_next   = '0;
                    mode_next   = MODE_FULL;
                    state_next  = ST_READ;
                end
                else
                begin
                    state_next = ST_P_INIT;
                end
            end
            ST_P_INIT:
            begin
                lo_next    = '0;
                hi_next    = total;
                first_next = total;
                if (key_len_reg != '0 && key_len_reg < slots)
                begin
                    state_next = ST_P_CHECK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_P_CHECK:
            begin
                if (lo_reg < hi_reg)
                begin
                    probe_next  = mid;
                    rd_len_next = key_len_reg;
                    rd_i_next   = '0;
                    mode_next   = MODE_PREFIX;
                    state_next  = ST_READ;
                end
                else
                begin
                    lo_next    = first_reg;
                    state_next = ST_S_CHECK;
                end
            end
            ST_S_CHECK:
            begin
                if (lo_reg < total)
                begin
                    probe_next  = lo_reg;
                    rd_len_next = key_len_reg + LEN_W'(1);
                    rd_i_next   = '0;
                    mode_next   = MODE_SCAN;
                    state_next  = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                rd_i_next = rd_i_reg + LEN_W'(1);
                if (rd_i_reg + LEN_W'(1) == rd_len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                unique case (mode_reg)
                    MODE_FULL:
                    begin
                        if (!cmp_res.full_lt && !cmp_res.full_gt)
                        begin
                            found_next = 1'b1;
                            state_next = ST_OFS_READ;
                        end
                        else if (cmp_res.full_lt)
                        begin
                            hi_next    = probe_reg;
                            state_next = ST_F_CHECK;
                        end
                        else
                        begin
                            lo_next    = probe_reg + TOTAL_W'(1);
                            state_next = ST_F_CHECK;
                        end
                    end
                    MODE_PREFIX:
                    begin
                        if (cmp_res.pre_ge)
                        begin
                            first_next = probe_reg;
                            hi_next    = probe_reg;
                        end
                        else
                        begin
                            lo_next = probe_reg + TOTAL_W'(1);
                        end
                        state_next = ST_P_CHECK;
                    end
                    MODE_SCAN:
                    begin
                        if (!cmp_res.pre_eq)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (cmp_res.ext_nz)
                        begin
                            longer_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            lo_next    = lo_reg + TOTAL_W'(1);
                            state_next = ST_S_CHECK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_OFS_READ:
            begin
                state_next = ST_OFS_WAIT;
            end
            ST_OFS_WAIT:
            begin
                offset_next = ram_rdata;
                state_next  = ST_P_INIT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_FULL;
            spe_reg     <= SPE_W'(STROKE_SLOTS);
            eiu_reg     <= '0;
            key_len_reg <= '0;
            key_ovf_reg <= 1'b0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            dv_reg    <= (state_reg == ST_READ);
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_STROKES: spe_reg <= cfg_data[SPE_W-1:0];
                    CFG_ENTRIES: eiu_reg <= cfg_data;
                    default:     eiu_reg <= eiu_reg;
                endcase
            end
            if (key_clear)
            begin
                key_len_reg <= '0;
                key_ovf_reg <= 1'b0;
            end
            else if (s_fire && s_tuser == ACT_STROKE)
            begin
                if (key_len_reg < LEN_W'(STROKE_SLOTS))
                begin
                    key_len_reg <= key_len_reg + LEN_W'(1);
                end
                else
                begin
                    key_ovf_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        first_reg   <= first_next;
        probe_reg   <= probe_next;
        rd_len_reg  <= rd_len_next;
        rd_i_reg    <= rd_i_next;
        di_reg      <= rd_i_reg[KIDX_W-1:0];
        found_reg   <= found_next;
        offset_reg  <= offset_next;
        longer_reg  <= longer_next;
        ovf_res_reg <= ovf_res_next;
        if (s_fire && s_tuser == ACT_STROKE && key_len_reg < LEN_W'(STROKE_SLOTS))
        begin
            key_reg[key_len_reg[KIDX_W-1:0]] <= in_stroke;
        end
        if (load_out)
        begin
            m_data_reg <= {(M_DATA_W-WORD_W-3)'(0), ovf_res_reg, longer_reg,
                           offset_reg, found_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= LEN_W'(STROKE_SLOTS))
        else $error("key length past stroke limit");

    a_found_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[WORD_W+2]))
        else $error("match reported on overlong key");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[WORD_W:1] == '0))
        else $error("offset nonzero without match");

    a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("table write during search read");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted chord dictionary search: loads sorted
// stroke tables over the request stream, sends exact, prefix, perturbed,
// random and overlong keys, and checks each search result against an
// in-bench predictor of both binary searches and the forward scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import scds_pkg::*;

    localparam int ENTRY_WORDS = STROKE_SLOTS + 1;
    localparam int IDLE_LIMIT  = 200000;

    typedef struct {
        logic        act;
        logic [9:0]  idx;
        logic [4:0]  slot;
        logic [31:0] val;
        logic [31:0] stroke;
        logic        last;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic        longer;
        logic        too_long;
    } lookup_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_addr;
    logic [TOTAL_W-1:0]  cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    sorted_chord_dictionary_search uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state
    logic [31:0] dict_words [MAX_ENTRIES][ENTRY_WORDS];
    logic [31:0] key_words [STROKE_SLOTS];
    int          key_count;
    logic        key_overflow;
    int          slots_reg;
    int          entries_reg;

    // generated table contents, used to build meaningful keys
    logic [31:0] gen_strokes [MAX_ENTRIES][STROKE_SLOTS];
    int          gen_len [MAX_ENTRIES];

    request_t    request_q [$];
    lookup_t     expected_lookups [$];
    logic [31:0] key_build [$];
    request_t    cur_req;
    bit          offered;
    bit          no_gaps;
    bit          failed;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int order_full(int e, int cnt, int slots);
        int elen;
        int n;
        elen = 0;
        for (int i = 0; i < slots; i++)
            if (dict_words[e][i] != 0)
                elen = i + 1;
        n = (cnt < elen) ? cnt : elen;
        for (int i = 0; i < n; i++)
        begin
            if (key_words[i] < dict_words[e][i]) return -1;
            if (key_words[i] > dict_words[e][i]) return 1;
        end
        if (cnt < elen) return -1;
        if (cnt > elen) return 1;
        return 0;
    endfunction

    function automatic int order_prefix(int e, int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if (dict_words[e][i] < key_words[i]) return -1;
            if (dict_words[e][i] > key_words[i]) return 1;
        end
        return 0;
    endfunction

    function automatic lookup_t search_dictionary();
        lookup_t r;
        int      slots;
        int      total;
        int      lo;
        int      hi;
        int      mid;
        int      first;
        int      c;
        r     = '0;
        slots = (slots_reg > STROKE_SLOTS) ? STROKE_SLOTS : slots_reg;
        total = (entries_reg > MAX_ENTRIES) ? MAX_ENTRIES : entries_reg;
        if (key_overflow)
        begin
            r.too_long = 1'b1;
            return r;
        end
        if (key_count >= 1 && key_count <= slots)
        begin
            lo = 0;
            hi = total;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                c = order_full(mid, key_count, slots);
                if (c == 0)
                begin
                    r.found  = 1'b1;
                    r.offset = dict_words[mid][STROKE_SLOTS];
                    break;
                end
                if (c < 0) hi = mid;
                else lo = mid + 1;
            end
        end
        if (key_count >= 1 && key_count < slots)
        begin
            lo    = 0;
            hi    = total;
            first = total;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (order_prefix(mid, key_count) >= 0)
                begin
                    first = mid;
                    hi    = mid;
                end
                else
                    lo = mid + 1;
            end
            for (int e = first; e < total; e++)
            begin
                if (order_prefix(e, key_count) != 0) break;
                if (dict_words[e][key_count] != 0)
                begin
                    r.longer = 1'b1;
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic void apply_request(request_t r);
        if (r.act == ACT_WRITE)
        begin
            // slots past the offset word are dropped
            if (r.slot <= OFFSET_SLOT)
                dict_words[r.idx][r.slot] = r.val;
            return;
        end
        if (key_count < STROKE_SLOTS)
        begin
            key_words[key_count] = r.stroke;
            key_count++;
        end
        else
            key_overflow = 1'b1;
        if (r.last)
        begin
            expected_lookups.push_back(search_dictionary());
            for (int i = 0; i < STROKE_SLOTS; i++)
                key_words[i] = '0;
            key_count    = 0;
            key_overflow = 1'b0;
        end
    endfunction

    // accept side: prediction, result check and watchdog
    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
            begin
                apply_request(cur_req);
                offered = 1'b0;
            end
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[34]};
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.found != want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, got.found);
                        failed = 1'b1;
                    end
                    if (got.offset != want.offset)
                    begin
                        $display("%0t: string_offset expected %h actual %h",
                                 $time, want.offset, got.offset);
                        failed = 1'b1;
                    end
                    if (got.longer != want.longer)
                    begin
                        $display("%0t: has_longer expected %0d actual %0d",
                                 $time, want.longer, got.longer);
                        failed = 1'b1;
                    end
                    if (got.too_long != want.too_long)
                    begin
                        $display("%0t: key_too_long expected %0d actual %0d",
                                 $time, want.too_long, got.too_long);
                        failed = 1'b1;
                    end
                end
            end
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("sorted_chord_dictionary_search regression: fail");
                $finish;
            end
        end
    end

    // request driver and result stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 25);
            if (!offered)
            begin
                if (request_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 25))
                begin
                    cur_req = request_q.pop_front();
                    offered = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.act;
                    s_tlast  <= cur_req.last;
                    s_tdata  <= {1'b0, cur_req.stroke, cur_req.val, cur_req.slot, cur_req.idx};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic push_write(int e, int s, logic [31:0] v);
        request_t r;
        r = '{ACT_WRITE, e[9:0], s[4:0], v, $urandom, 1'($urandom)};
        request_q.push_back(r);
    endtask

    // send the collected key strokes, the last one marked
    task automatic push_key();
        request_t r;
        for (int i = 0; i < key_build.size(); i++)
        begin
            r = '{ACT_STROKE, 10'($urandom), 5'($urandom), $urandom, key_build[i],
                  i == key_build.size() - 1};
            request_q.push_back(r);
        end
        key_build.delete();
    endtask

    function automatic logic [31:0] pick_stroke();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    // build n entries in strictly ascending order over g slots
    task automatic build_table(int n, int g);
        int p;
        int top;
        gen_len[0] = $urandom_range(1, g);
        for (int i = 0; i < STROKE_SLOTS; i++)
            gen_strokes[0][i] = (i < gen_len[0]) ? 32'($urandom_range(1, 3)) : '0;
        for (int e = 1; e < n; e++)
        begin
            gen_strokes[e] = gen_strokes[e-1];
            gen_len[e]     = gen_len[e-1];
            top = (gen_len[e] < g) ? gen_len[e] : g - 1;
            p = $urandom_range(0, top);
            if (p == gen_len[e])
            begin
                gen_strokes[e][p] = $urandom_range(1, 3);
                gen_len[e]        = p + 1;
            end
            else
            begin
                gen_strokes[e][p] += $urandom_range(1, 2);
                for (int i = p + 1; i < STROKE_SLOTS; i++)
                    gen_strokes[e][i] = '0;
                gen_len[e] = p + 1;
                if ($urandom_range(0, 1) && gen_len[e] < g)
                begin
                    gen_len[e] = $urandom_range(gen_len[e] + 1, g);
                    for (int i = p + 1; i < gen_len[e]; i++)
                        gen_strokes[e][i] = $urandom_range(0, 3);
                    gen_strokes[e][gen_len[e]-1] = $urandom_range(1, 3);
                end
            end
        end
        for (int e = 0; e < n; e++)
        begin
            for (int s = 0; s < g; s++)
                push_write(e, s, gen_strokes[e][s]);
            // a slot beyond those in use carries junk now and then
            if (g < STROKE_SLOTS && $urandom_range(0, 3) == 0)
                push_write(e, $urandom_range(g, STROKE_SLOTS - 1), $urandom);
            push_write(e, STROKE_SLOTS, $urandom);
        end
    endtask

    task automatic queue_keys(int n, int cnt);
        int e;
        int len;
        int mode;
        for (int k = 0; k < cnt; k++)
        begin
            e    = (n > 0) ? $urandom_range(0, n - 1) : 0;
            mode = (n > 0) ? $urandom_range(0, 9) : $urandom_range(6, 9);
            case (mode)
                0, 1, 2:
                    for (int i = 0; i < gen_len[e]; i++)
                        key_build.push_back(gen_strokes[e][i]);
                3, 4:
                begin
                    len = $urandom_range(1, gen_len[e]);
                    for (int i = 0; i < len; i++)
                        key_build.push_back(gen_strokes[e][i]);
                end
                5:
                begin
                    for (int i = 0; i < gen_len[e]; i++)
                        key_build.push_back(gen_strokes[e][i]);
                    key_build[key_build.size()-1] += $urandom_range(0, 1) ? 1 : -1;
                end
                6, 7:
                begin
                    len = $urandom_range(1, STROKE_SLOTS);
                    for (int i = 0; i < len; i++)
                        key_build.push_back(pick_stroke());
                end
                8:
                    for (int i = 0; i < STROKE_SLOTS; i++)
                        key_build.push_back(pick_stroke());
                default:
                begin
                    len = $urandom_range(STROKE_SLOTS + 1, STROKE_SLOTS + 4);
                    for (int i = 0; i < len; i++)
                        key_build.push_back(pick_stroke());
                end
            endcase
            push_key();
        end
    endtask

    // hold until every request is taken and every result is back
    task automatic settle();
        while (request_q.size() > 0 || offered || expected_lookups.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value[TOTAL_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_STROKES) slots_reg = value & 32'h1F;
        else entries_reg = value & 32'h7FF;
    endtask

    task automatic run_phase(int spe, int entries, int n, int keys);
        int g;
        write_reg(CFG_STROKES, spe);
        write_reg(CFG_ENTRIES, entries);
        g = (spe < 1) ? 1 : (spe > STROKE_SLOTS) ? STROKE_SLOTS : spe;
        build_table(n, g);
        queue_keys(n, keys);
        settle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_STROKES;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_WRITE;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        offered      = 1'b0;
        no_gaps      = 1'b0;
        failed       = 1'b0;
        idle_cycles  = 0;
        key_count    = 0;
        key_overflow = 1'b0;
        slots_reg    = STROKE_SLOTS;
        entries_reg  = 0;
        for (int i = 0; i < STROKE_SLOTS; i++)
            key_words[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: single stroke, overlong key, dropped slot writes
        key_build.push_back('1);
        push_key();
        for (int i = 0; i < STROKE_SLOTS + 1; i++)
            key_build.push_back(i[0] ? '1 : '0);
        push_key();
        push_write(MAX_ENTRIES - 1, STROKE_SLOTS + 1, '1);
        push_write(MAX_ENTRIES - 1, 31, '1);
        key_build.push_back('0);
        push_key();
        settle();

        // small table, slot register past its range: every entry hit
        // directly, then random keys
        write_reg(CFG_STROKES, 31);
        write_reg(CFG_ENTRIES, 4);
        build_table(4, STROKE_SLOTS);
        for (int e = 0; e < 4; e++)
        begin
            for (int i = 0; i < gen_len[e]; i++)
                key_build.push_back(gen_strokes[e][i]);
            push_key();
        end
        queue_keys(4, 4);
        settle();

        no_gaps = 1'b1;
        run_phase(1, 8, 8, 12);
        no_gaps = 1'b0;
        run_phase(5, 16, 16, 18);
        run_phase(0, 4, 4, 6);

        settle();
        repeat (50) @(posedge clk);
        if (!failed)
            $display("sorted_chord_dictionary_search regression: pass");
        else
            $display("sorted_chord_dictionary_search regression: fail");
        $finish;
    end

endmodule
